// File: hdl/hct_pkg.sv
// Package for the character tokenizer: item types, token codes, known words
// and the word classification function. No dependencies.
package hct_pkg;

  localparam int unsigned PositionBitsDefault = 16;
  localparam int unsigned OutPosBits          = 16;

  localparam logic       ActChar = 1'b0;
  localparam logic       ActEnd  = 1'b1;

  localparam logic       KindToken  = 1'b0;
  localparam logic       KindStatus = 1'b1;

  localparam logic [1:0] TokKeyword   = 2'd0;
  localparam logic [1:0] TokOperator  = 2'd1;
  localparam logic [1:0] TokSeparator = 2'd2;
  localparam logic [1:0] TokUnknown   = 2'd3;

  localparam logic       StatOk    = 1'b0;
  localparam logic       StatEmpty = 1'b1;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChComma   = 8'h2C;
  localparam logic [7:0] ChSemi    = 8'h3B;

  // Prefixes hold the first character in bits 7..0, unused bytes zero
  localparam logic [31:0] WordWireLc = {"e", "r", "i", "w"};
  localparam logic [31:0] WordWireUc = {"e", "r", "i", "W"};
  localparam logic [31:0] WordLe     = {16'h0, "=", "<"};
  localparam logic [31:0] WordNot    = {8'h0, "t", "o", "n"};
  localparam logic [31:0] WordBang   = {24'h0, "!"};
  localparam logic [31:0] WordAnd    = {8'h0, "d", "n", "a"};
  localparam logic [31:0] WordAmp    = {24'h0, "&"};
  localparam logic [31:0] WordOr     = {16'h0, "r", "o"};
  localparam logic [31:0] WordBar    = {24'h0, "|"};
  localparam logic [31:0] WordXor    = {8'h0, "r", "o", "x"};
  localparam logic [31:0] WordCaret  = {24'h0, "^"};

  typedef struct packed {
    logic       action;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic        result_kind;
    logic [1:0]  token_type;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        status;
    logic        last;
  } out_item_t;

  // len is the word length when it is 1..4, else 0
  function automatic logic [1:0] classify_word(input logic [31:0] prefix,
                                               input logic [2:0]  len);
    logic is_op;
    logic is_kw;
    is_op = ((len == 3'd1) && (prefix == WordBang || prefix == WordAmp ||
                               prefix == WordBar  || prefix == WordCaret)) ||
            ((len == 3'd2) && (prefix == WordLe || prefix == WordOr)) ||
            ((len == 3'd3) && (prefix == WordNot || prefix == WordAnd ||
                               prefix == WordXor));
    is_kw = (len == 3'd4) && (prefix == WordWireLc || prefix == WordWireUc);
    if (is_op) begin
      return TokOperator;
    end else if (is_kw) begin
      return TokKeyword;
    end else begin
      return TokUnknown;
    end
  endfunction

endpackage

// File: hdl/hdl_char_tokenizer.sv
// An item's results are offered, behind earlier ones, from the cycle after it
// is accepted. Throughput: one item per cycle while the four-entry result
// queue has room for two results; the queue drains one result per cycle while
// out_ready_i is high, so items giving two results are limited by the output
// side. Reset (rst_ni low, asynchronous) clears the word state, the position
// counter and the queue. Top level of the tokenizer; uses hct_pkg.
module hdl_char_tokenizer import hct_pkg::*; #(
  parameter int unsigned PositionBits = PositionBitsDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned WideBits = (PositionBits > OutPosBits) ? PositionBits : OutPosBits;

  logic [31:0]             word_prefix_q, word_prefix_d;
  logic [PositionBits-1:0] word_length_q, word_length_d;
  logic [PositionBits-1:0] word_start_q, word_start_d;
  logic [PositionBits-1:0] char_position_q, char_position_d;
  logic                    seen_char_q, seen_char_d;

  out_item_t  queue_q [4];
  logic [1:0] wr_ptr_q, rd_ptr_q;
  logic [2:0] count_q;

  logic       in_fire, out_fire;
  logic [1:0] n_push;
  out_item_t  res0, res1;
  out_item_t  word_tok, sep_tok, stat_res;
  logic       have_word, is_space, is_sep;
  logic [2:0] len_small;
  logic [WideBits-1:0] start_wide, len_wide, pos_wide;
  logic [31:0] prefix_base;

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;

  assign have_word = (word_length_q != '0);
  assign is_space  = (in_item_i.char_code == ChSpace) || (in_item_i.char_code == ChNewline);
  assign is_sep    = (in_item_i.char_code == ChLParen) || (in_item_i.char_code == ChRParen) ||
                     (in_item_i.char_code == ChComma)  || (in_item_i.char_code == ChSemi);
  assign len_small = (word_length_q <= PositionBits'(4)) ? word_length_q[2:0] : 3'd0;

  assign start_wide = WideBits'(word_start_q);
  assign len_wide   = WideBits'(word_length_q);
  assign pos_wide   = WideBits'(char_position_q);

  always_comb begin
    word_tok              = '0;
    word_tok.result_kind  = KindToken;
    word_tok.token_type   = classify_word(word_prefix_q, len_small);
    word_tok.token_start  = start_wide[OutPosBits-1:0];
    word_tok.token_length = len_wide[OutPosBits-1:0];
    word_tok.status       = StatOk;

    sep_tok              = '0;
    sep_tok.result_kind  = KindToken;
    sep_tok.token_type   = TokSeparator;
    sep_tok.token_start  = pos_wide[OutPosBits-1:0];
    sep_tok.token_length = OutPosBits'(1);
    sep_tok.status       = StatOk;
    sep_tok.last         = 1'b1;

    stat_res             = '0;
    stat_res.result_kind = KindStatus;
    stat_res.status      = seen_char_q ? StatOk : StatEmpty;
    stat_res.last        = 1'b1;
  end

  assign prefix_base = have_word ? word_prefix_q : 32'h0;

  always_comb begin
    word_prefix_d   = word_prefix_q;
    word_length_d   = word_length_q;
    word_start_d    = word_start_q;
    char_position_d = char_position_q;
    seen_char_d     = seen_char_q;
    res0            = word_tok;
    res1            = stat_res;
    n_push          = 2'd0;

    if (in_item_i.action == ActEnd) begin
      res0            = have_word ? word_tok : stat_res;
      res1            = stat_res;
      n_push          = have_word ? 2'd2 : 2'd1;
      word_prefix_d   = '0;
      word_length_d   = '0;
      word_start_d    = '0;
      char_position_d = '0;
      seen_char_d     = 1'b0;
    end else begin
      seen_char_d     = 1'b1;
      char_position_d = char_position_q + PositionBits'(1);
      if (is_space) begin
        res0.last     = 1'b1;
        n_push        = {1'b0, have_word};
        word_prefix_d = '0;
        word_length_d = '0;
        word_start_d  = '0;
      end else if (is_sep) begin
        res0          = have_word ? word_tok : sep_tok;
        res1          = sep_tok;
        n_push        = have_word ? 2'd2 : 2'd1;
        word_prefix_d = '0;
        word_length_d = '0;
        word_start_d  = '0;
      end else begin
        if (!have_word) begin
          word_start_d = char_position_q;
        end
        if (word_length_q < PositionBits'(4)) begin
          word_prefix_d = prefix_base |
                          ({24'h0, in_item_i.char_code} << {word_length_q[1:0], 3'b000});
        end else begin
          word_prefix_d = prefix_base;
        end
        word_length_d = word_length_q + PositionBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      word_prefix_q   <= '0;
      word_length_q   <= '0;
      word_start_q    <= '0;
      char_position_q <= '0;
      seen_char_q     <= 1'b0;
    end else if (in_fire) begin
      word_prefix_q   <= word_prefix_d;
      word_length_q   <= word_length_d;
      word_start_q    <= word_start_d;
      char_position_q <= char_position_d;
      seen_char_q     <= seen_char_d;
    end
  end

  // result queue: up to two writes per item, one read per cycle while out_ready_i is high
  always_ff @(posedge clk_i) begin
    if (in_fire && (n_push != 2'd0)) begin
      queue_q[wr_ptr_q] <= res0;
    end
    if (in_fire && (n_push == 2'd2)) begin
      queue_q[wr_ptr_q + 2'd1] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr_q <= wr_ptr_q + n_push;
      end
      if (out_fire) begin
        rd_ptr_q <= rd_ptr_q + 2'd1;
      end
      count_q <= count_q + (in_fire ? {1'b0, n_push} : 3'd0) - {2'b00, out_fire};
    end
  end

  assign in_ready_o  = (count_q <= 3'd2);
  assign out_valid_o = (count_q != 3'd0);
  assign out_item_o  = queue_q[rd_ptr_q];

endmodule

// File: hdl/hct_checker.sv
// Port-level checks for the tokenizer, attached by bind; uses hct_pkg.
// Watches the output channel only.
module hct_checker import hct_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind == KindStatus) |->
      out_item_o.last && (out_item_o.token_type == TokKeyword) &&
      (out_item_o.token_start == '0) && (out_item_o.token_length == '0))
    else $error("malformed status result");

  a_token_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind == KindToken) |->
      (out_item_o.status == StatOk))
    else $error("token result carries a status");

  a_sep_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.result_kind == KindToken) &&
    (out_item_o.token_type == TokSeparator) |->
      (out_item_o.token_length == 16'd1) && out_item_o.last)
    else $error("separator token malformed");

  a_after_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && (out_item_o.result_kind == KindToken) &&
    !out_item_o.last ##1 out_valid_o |->
      (out_item_o.result_kind == KindStatus) || (out_item_o.token_type == TokSeparator))
    else $error("word token not followed by its companion result");

endmodule

bind hdl_char_tokenizer hct_checker u_hct_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// File: tb/tb_hdl_char_tokenizer.sv
// Self-checking testbench for hdl_char_tokenizer: a directed table, then random
// text lines, all checked against a local token predictor.
// Depends on hct_pkg and the hdl_char_tokenizer top level.
`timescale 1ns / 100ps

module tb_hdl_char_tokenizer;
  import hct_pkg::*;

  localparam int unsigned QuietLimit  = 2000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned RandomItems = 1040;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } step_row_t;

  localparam out_item_t NoCheck  = '0;
  localparam out_item_t EndEmpty = '{KindStatus, 2'b00, 16'd0, 16'd0, StatEmpty, 1'b1};
  localparam out_item_t EndOk    = '{KindStatus, 2'b00, 16'd0, 16'd0, StatOk, 1'b1};
  localparam out_item_t FirstSep = '{KindToken, TokSeparator, 16'd0, 16'd1, StatOk, 1'b1};

  localparam step_row_t Steps [25] = '{
    '{'{ActEnd, 8'hFF}, 1'b1, EndEmpty},
    '{'{ActEnd, 8'h00}, 1'b1, EndEmpty},
    '{'{ActChar, ChLParen}, 1'b1, FirstSep},
    '{'{ActChar, "n"}, 1'b0, NoCheck},
    '{'{ActChar, "o"}, 1'b0, NoCheck},
    '{'{ActChar, "t"}, 1'b0, NoCheck},
    '{'{ActChar, ChRParen}, 1'b0, NoCheck},
    '{'{ActChar, "<"}, 1'b0, NoCheck},
    '{'{ActChar, "="}, 1'b0, NoCheck},
    '{'{ActChar, ChSpace}, 1'b0, NoCheck},
    '{'{ActChar, "W"}, 1'b0, NoCheck},
    '{'{ActChar, "i"}, 1'b0, NoCheck},
    '{'{ActChar, "r"}, 1'b0, NoCheck},
    '{'{ActChar, "e"}, 1'b0, NoCheck},
    '{'{ActChar, ChNewline}, 1'b0, NoCheck},
    '{'{ActChar, 8'h00}, 1'b0, NoCheck},
    '{'{ActChar, 8'hFF}, 1'b0, NoCheck},
    '{'{ActChar, ChSemi}, 1'b0, NoCheck},
    '{'{ActChar, "^"}, 1'b0, NoCheck},
    '{'{ActEnd, 8'hAA}, 1'b1, EndOk},
    '{'{ActChar, "x"}, 1'b0, NoCheck},
    '{'{ActChar, "o"}, 1'b0, NoCheck},
    '{'{ActChar, "r"}, 1'b0, NoCheck},
    '{'{ActChar, "x"}, 1'b0, NoCheck},
    '{'{ActEnd, 8'h55}, 1'b1, EndOk}
  };

  localparam logic [7:0] Delims [6] = '{ChSpace, ChNewline, ChLParen, ChRParen, ChComma, ChSemi};

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  // predictor state
  logic [31:0] word_text  = '0;
  logic [15:0] word_len   = '0;
  logic [15:0] word_pos   = '0;
  logic [15:0] next_pos   = '0;
  logic        any_char   = 1'b0;

  out_item_t   due_q [$];
  string       known_words [11] = '{"<=", "not", "!", "and", "&", "or", "|", "xor", "^",
                                    "wire", "Wire"};

  int unsigned errors       = 0;
  int unsigned items_in     = 0;
  int unsigned results_seen = 0;
  int unsigned ends_seen    = 0;
  int unsigned empties_seen = 0;
  int unsigned type_seen [4] = '{0, 0, 0, 0};
  int unsigned quiet_cycles = 0;
  int unsigned burst_left   = 0;
  bit          hold_req     = 1'b0;
  out_item_t   want;

  hdl_char_tokenizer #(
    .PositionBits(16)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [1:0] word_class(input logic [31:0] text, input logic [15:0] len);
    case ({len, text})
      {16'd1, 24'h0, "!"}, {16'd1, 24'h0, "&"}, {16'd1, 24'h0, "|"}, {16'd1, 24'h0, "^"},
      {16'd2, 16'h0, "=", "<"}, {16'd2, 16'h0, "r", "o"},
      {16'd3, 8'h0, "t", "o", "n"}, {16'd3, 8'h0, "d", "n", "a"},
      {16'd3, 8'h0, "r", "o", "x"}: return TokOperator;
      {16'd4, "e", "r", "i", "w"}, {16'd4, "e", "r", "i", "W"}: return TokKeyword;
      default: return TokUnknown;
    endcase
  endfunction

  function automatic out_item_t make_token(input logic [1:0] kind, input logic [15:0] start,
                                           input logic [15:0] len);
    out_item_t t;
    t = '0;
    t.result_kind  = KindToken;
    t.token_type   = kind;
    t.token_start  = start;
    t.token_length = len;
    return t;
  endfunction

  function automatic out_item_t close_word();
    out_item_t t;
    t = make_token(word_class(word_text, word_len), word_pos, word_len);
    word_text = '0;
    word_len  = '0;
    word_pos  = '0;
    return t;
  endfunction

  // results one item gives, with the predictor state moved on
  function automatic int tokenize(input in_item_t it, output out_item_t res [2]);
    int n;
    logic [15:0] pos;
    n = 0;
    pos = next_pos;
    res[0] = '0;
    res[1] = '0;
    if (it.action == ActEnd) begin
      if (word_len != 0) begin
        res[n] = close_word();
        n++;
      end
      res[n].result_kind = KindStatus;
      res[n].status = any_char ? StatOk : StatEmpty;
      n++;
      next_pos = '0;
      any_char = 1'b0;
    end else begin
      any_char = 1'b1;
      next_pos = pos + 16'd1;
      case (it.char_code)
        ChSpace, ChNewline: begin
          if (word_len != 0) begin
            res[n] = close_word();
            n++;
          end
        end
        ChLParen, ChRParen, ChComma, ChSemi: begin
          if (word_len != 0) begin
            res[n] = close_word();
            n++;
          end
          res[n] = make_token(TokSeparator, pos, 16'd1);
          n++;
        end
        default: begin
          if (word_len == 0) begin
            word_pos  = pos;
            word_text = '0;
          end
          if (word_len < 4) begin
            word_text[8 * word_len[1:0] +: 8] = it.char_code;
          end
          word_len = word_len + 16'd1;
        end
      endcase
    end
    if (n > 0) begin
      res[n - 1].last = 1'b1;
    end
    return n;
  endfunction

  task automatic offer(input in_item_t it, input logic typed = 1'b0,
                       input out_item_t fixed = '0);
    out_item_t res [2];
    int n;
    in_valid_i <= 1'b1;
    in_item_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    n = tokenize(it, res);
    if (typed) begin
      res[n - 1] = fixed;
    end
    for (int j = 0; j < n; j++) begin
      due_q = {due_q, res[j]};
    end
    items_in++;
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_char(input logic [7:0] c);
    offer(in_item_t'{ActChar, c});
    pace();
  endtask

  task automatic send_end();
    offer(in_item_t'{ActEnd, 8'($urandom_range(0, 255))});
    pace();
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_q.size() != 0);
  endtask

  function automatic logic [7:0] word_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    case (b)
      ChSpace, ChNewline, ChLParen, ChRParen, ChComma, ChSemi: b = b ^ 8'h40;
      default: ;
    endcase
    return b;
  endfunction

  // one text line: known words (some altered), random words and separators
  task automatic send_random_line();
    int pieces;
    int kind;
    int k;
    string w;
    logic [7:0] word_q [$];
    pieces = $urandom_range(0, 10);
    for (int p = 0; p < pieces; p++) begin
      kind = $urandom_range(0, 9);
      word_q = {};
      if (kind < 5) begin
        w = known_words[$urandom_range(0, 10)];
        for (int j = 0; j < w.len(); j++) begin
          word_q = {word_q, w[j]};
        end
        k = $urandom_range(0, 9);
        if (k == 0 && word_q.size() > 1) begin
          void'(word_q.pop_back());
        end else if (k == 1) begin
          word_q = {word_q, word_byte()};
        end else if (k == 2) begin
          word_q[0] = word_q[0] ^ 8'h20;
        end
      end else if (kind < 8) begin
        repeat ($urandom_range(1, 6)) word_q = {word_q, word_byte()};
      end
      foreach (word_q[j]) begin
        send_char(word_q[j]);
      end
      if (p != pieces - 1 || $urandom_range(0, 1) == 1) begin
        send_char(Delims[$urandom_range(0, 5)]);
      end
    end
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        offer(in_item_t'(9'($urandom_range(0, 511))));
        pace();
      end
    end
    send_end();
  endtask

  task automatic flag_field(input string name, input int unsigned exp_v,
                            input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_q.size() == 0) begin
        $display("%0t: result with nothing due: %p", $time, out_item_o);
        errors++;
      end else begin
        want = due_q.pop_front();
        flag_field("result_kind", want.result_kind, out_item_o.result_kind);
        flag_field("token_type", want.token_type, out_item_o.token_type);
        flag_field("token_start", want.token_start, out_item_o.token_start);
        flag_field("token_length", want.token_length, out_item_o.token_length);
        flag_field("status", want.status, out_item_o.status);
        flag_field("last", want.last, out_item_o.last);
        results_seen++;
        if (want.result_kind == KindStatus) begin
          ends_seen++;
          if (want.status == StatEmpty) begin
            empties_seen++;
          end
        end else begin
          type_seen[want.token_type]++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QuietLimit) begin
      $display("%0t: watchdog, no item moved for %0d cycles, %0d results due",
               $time, quiet_cycles, due_q.size());
      $display("tb_hdl_char_tokenizer: done, errors");
      $finish;
    end
  end

  // result side: stall patterns that change now and then, plus one long hold-off
  initial begin
    int mode;
    int unsigned tick;
    tick = 0;
    forever begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(20, 80)) begin
        @(posedge clk_i);
        if (hold_req) begin
          out_ready_i <= 1'b0;
          repeat (HoldCycles) @(posedge clk_i);
          hold_req = 1'b0;
        end
        tick++;
        case (mode)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= 1'($urandom_range(0, 1));
          2: out_ready_i <= ($urandom_range(0, 3) == 0);
          default: out_ready_i <= (tick % 4 != 3);
        endcase
      end
    end
  end

  initial begin
    int unsigned lines;
    int unsigned rand_goal;
    lines = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (Steps[i]) begin
      offer(Steps[i].item, Steps[i].typed, Steps[i].want);
      pace();
    end
    wait_drained();

    rand_goal = items_in + RandomItems;
    while (items_in < rand_goal) begin
      lines++;
      if (lines == 30) begin
        hold_req = 1'b1;
        repeat (16) begin
          offer(in_item_t'{ActChar, "q"});
          offer(in_item_t'{ActChar, ChRParen});
        end
        offer(in_item_t'{ActEnd, 8'h00});
      end
      if (lines % 100 == 50) begin
        wait_drained();
      end
      send_random_line();
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (due_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, due_q.size());
      errors++;
    end

    $display("%0d items over %0d text lines, %0d results checked, with one long output stall",
             items_in, lines, results_seen);
    $display("tokens: %0d keyword, %0d operator, %0d separator, %0d unknown; %s",
             type_seen[TokKeyword], type_seen[TokOperator], type_seen[TokSeparator],
             type_seen[TokUnknown], $sformatf("%0d ends, %0d empty", ends_seen, empties_seen));
    if (errors == 0) begin
      $display("tb_hdl_char_tokenizer: done, clean");
    end else begin
      $display("tb_hdl_char_tokenizer: done, errors");
    end
    $finish;
  end

endmodule

// File: hdl_char_tokenizer.f
hdl/hct_pkg.sv
hdl/hdl_char_tokenizer.sv
hdl/hct_checker.sv
tb/tb_hdl_char_tokenizer.sv
